// ===== rtl/core/fnas_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, types and a helper function for the four-neighbour average stencil.
package fnas_pkg;

   localparam int PIXEL_W        = 16;
   localparam int ROW_W          = 16;
   localparam int COL_W          = 11;
   localparam int LEN_W          = 12;
   localparam int MAX_ROW_LENGTH = 2048;
   localparam int CSR_INDEX_W    = 1;
   localparam int CSR_DATA_W     = 16;

   localparam logic [CSR_INDEX_W-1:0] REG_ROW_LENGTH = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_ROW_COUNT  = 1'd1;

   localparam logic [LEN_W-1:0] ROW_LENGTH_RESET = 12'd1082;
   localparam logic [ROW_W-1:0] ROW_COUNT_RESET  = 16'd1922;
   localparam logic [LEN_W-1:0] MIN_LENGTH       = 12'd3;
   localparam logic [LEN_W-1:0] MAX_LENGTH       = LEN_W'(MAX_ROW_LENGTH);
   localparam logic [ROW_W-1:0] MIN_COUNT        = 16'd3;

   // One line memory entry: the pixel two rows up and the pixel one row up.
   typedef struct packed {
      logic [PIXEL_W-1:0] upper;
      logic [PIXEL_W-1:0] centre;
   } line_word_type;

   // Position of the pixel on the input channel, and what the datapath needs from it.
   typedef struct packed {
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] col;
      logic [COL_W-1:0] col_next;
      logic [COL_W-1:0] col_next2;
      logic [COL_W-1:0] fill_col;
      logic [COL_W-1:0] fill_next;
      logic             interior;
      logic             last;
   } pos_type;

   typedef struct packed {
      logic [PIXEL_W-1:0] average;
      logic [ROW_W-1:0]   row_index;
      logic [COL_W-1:0]   column_index;
      logic               frame_last;
   } result_type;

   // Column that follows col in a row of the given width.
   function automatic logic [COL_W-1:0] next_column(input logic [COL_W-1:0] col,
                                                    input logic [LEN_W-1:0] width);
      logic [LEN_W-1:0] inc;
      inc = {1'b0, col} + LEN_W'(1);
      if (inc >= width) begin
         next_column = '0;
      end else begin
         next_column = inc[COL_W-1:0];
      end
   endfunction

endpackage

// ===== rtl/core/four_neighbour_average_stencil_core.sv =====
`timescale 1ns / 1ps
// A result is pushed into the output buffer on the transfer of the pixel below its centre.
// One pixel per cycle while req_stall is low, each with one read and one write of line memory.
// Reset clears counters and output buffer and presets frame registers; line RAM is not cleared.
// After reset and after every csr write, req_stall is high in the FILL_CUR and FILL_NXT
// states while the two-entry column window is reloaded; a frame_start pixel off column
// zero is held for a position clear and the same reload; a full skid entry holds the input.
module four_neighbour_average_stencil_core (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [fnas_pkg::PIXEL_W-1:0]          req_pixel,
   input  logic                                  req_frame_start,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [fnas_pkg::PIXEL_W-1:0]          rsp_average,
   output logic [fnas_pkg::ROW_W-1:0]            rsp_row_index,
   output logic [fnas_pkg::COL_W-1:0]            rsp_column_index,
   output logic                                  rsp_frame_last,
   input  logic                                  csr_write,
   input  logic [fnas_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [fnas_pkg::CSR_DATA_W-1:0]       csr_data
);

   localparam logic [1:0] FILL_DONE = 2'd0;
   localparam logic [1:0] FILL_CUR  = 2'd1;
   localparam logic [1:0] FILL_NXT  = 2'd2;

   logic [1:0]              fill_ff, fill_in;
   fnas_pkg::line_word_type cur_ff, cur_in;
   logic [fnas_pkg::PIXEL_W-1:0] left_ff, left_in;
   fnas_pkg::line_word_type nxt;
   fnas_pkg::line_word_type wr_word;
   fnas_pkg::pos_type       pos;
   fnas_pkg::result_type    result;
   fnas_pkg::result_type    rsp_data;
   logic                    accept;
   logic                    rewind;
   logic                    buf_full;
   logic                    rd_en;
   logic [fnas_pkg::COL_W-1:0] rd_addr;
   logic [$bits(fnas_pkg::line_word_type)-1:0] rd_data;
   logic [fnas_pkg::PIXEL_W+1:0] sum;

   // Frame start away from column zero: clear the position first, then reload the window.
   assign rewind    = (fill_ff == FILL_DONE) && req_valid && req_frame_start
                      && (pos.fill_col != '0);
   assign req_stall = buf_full || (fill_ff != FILL_DONE) || rewind;
   assign accept    = req_valid && !req_stall;

   fnas_position u_position (
      .clock       (clock),
      .reset       (reset),
      .advance     (accept),
      .rewind      (rewind),
      .frame_start (req_frame_start),
      .csr_write   (csr_write),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .pos         (pos)
   );

   // Window: cur_ff holds the entry of the arriving column, the RAM output the next one.
   // Columns only step by one or jump to zero, and rows are at least three wide, so the
   // entry read ahead is never the one written in the same cycle.
   assign nxt = fnas_pkg::line_word_type'(rd_data);

   assign wr_word.upper  = cur_ff.centre;
   assign wr_word.centre = req_pixel;

   always_comb begin
      rd_en   = accept;
      rd_addr = pos.col_next2;
      case (fill_ff)
         FILL_CUR: begin
            rd_en   = 1'b1;
            rd_addr = pos.fill_col;
         end
         FILL_NXT: begin
            rd_en   = 1'b1;
            rd_addr = pos.fill_next;
         end
         default: ;
      endcase
   end

   fnas_ram #(
      .WIDTH ($bits(fnas_pkg::line_word_type)),
      .DEPTH (fnas_pkg::MAX_ROW_LENGTH)
   ) u_line_ram (
      .clock      (clock),
      .write_en   (accept),
      .write_addr (pos.col),
      .write_data (wr_word),
      .read_en    (rd_en),
      .read_addr  (rd_addr),
      .read_data  (rd_data)
   );

   always_comb begin
      fill_in = fill_ff;
      cur_in  = cur_ff;
      left_in = left_ff;
      case (fill_ff)
         FILL_CUR: fill_in = FILL_NXT;
         FILL_NXT: begin
            fill_in = FILL_DONE;
            cur_in  = nxt;
         end
         default: begin
            if (accept) begin
               cur_in  = nxt;
               left_in = cur_ff.centre;
            end
         end
      endcase
      // Reload the window whenever the frame geometry changes or the column jumps to zero.
      if (csr_write || rewind) begin
         fill_in = FILL_CUR;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= FILL_CUR;
      end else begin
         fill_ff <= fill_in;
      end
      cur_ff  <= cur_in;
      left_ff <= left_in;
   end

   assign sum = {2'b00, cur_ff.upper} + {2'b00, left_ff} + {2'b00, nxt.centre}
                + {2'b00, req_pixel};

   assign result.average      = sum[fnas_pkg::PIXEL_W+1:2];
   assign result.row_index    = pos.row - fnas_pkg::ROW_W'(1);
   assign result.column_index = pos.col;
   assign result.frame_last   = pos.last;

   fnas_out_buffer u_out_buffer (
      .clock     (clock),
      .reset     (reset),
      .push      (accept && pos.interior),
      .push_data (result),
      .rsp_stall (rsp_stall),
      .full      (buf_full),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   assign rsp_average      = rsp_data.average;
   assign rsp_row_index    = rsp_data.row_index;
   assign rsp_column_index = rsp_data.column_index;
   assign rsp_frame_last   = rsp_data.frame_last;

endmodule

// ===== rtl/core/fnas_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read synchronous RAM with registered read data.
module fnas_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     write_en,
   input  logic [$clog2(DEPTH)-1:0] write_addr,
   input  logic [WIDTH-1:0]         write_data,
   input  logic                     read_en,
   input  logic [$clog2(DEPTH)-1:0] read_addr,
   output logic [WIDTH-1:0]         read_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   always_ff @(posedge clock) begin
      if (write_en) begin
         mem_ff[write_addr] <= write_data;
      end
      if (read_en) begin
         read_data_ff <= mem_ff[read_addr];
      end
   end

   assign read_data = read_data_ff;

endmodule

// ===== rtl/core/fnas_position.sv =====
`timescale 1ns / 1ps
// Frame registers and raster position counters with look-ahead column addresses.
module fnas_position (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  advance,
   input  logic                                  rewind,
   input  logic                                  frame_start,
   input  logic                                  csr_write,
   input  logic [fnas_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [fnas_pkg::CSR_DATA_W-1:0]       csr_data,
   output fnas_pkg::pos_type                     pos
);

   logic [fnas_pkg::LEN_W-1:0] row_length_ff;
   logic [fnas_pkg::ROW_W-1:0] row_count_ff;
   logic [fnas_pkg::ROW_W-1:0] row_ff, row_in;
   logic [fnas_pkg::COL_W-1:0] col_ff, col_in;

   logic [fnas_pkg::LEN_W-1:0] eff_w;
   logic [fnas_pkg::ROW_W-1:0] eff_h;
   logic [fnas_pkg::ROW_W-1:0] r;
   logic [fnas_pkg::COL_W-1:0] c;
   logic [fnas_pkg::LEN_W-1:0] c_ext;
   logic [fnas_pkg::ROW_W:0]   r_inc;

   always_comb begin
      if (row_length_ff < fnas_pkg::MIN_LENGTH) begin
         eff_w = fnas_pkg::MIN_LENGTH;
      end else if (row_length_ff > fnas_pkg::MAX_LENGTH) begin
         eff_w = fnas_pkg::MAX_LENGTH;
      end else begin
         eff_w = row_length_ff;
      end
      eff_h = (row_count_ff < fnas_pkg::MIN_COUNT) ? fnas_pkg::MIN_COUNT : row_count_ff;
   end

   assign r     = frame_start ? '0 : row_ff;
   assign c     = frame_start ? '0 : col_ff;
   assign c_ext = {1'b0, c};
   assign r_inc = {1'b0, r} + (fnas_pkg::ROW_W+1)'(1);

   always_comb begin
      pos.row       = r;
      pos.col       = c;
      pos.col_next  = fnas_pkg::next_column(c, eff_w);
      pos.col_next2 = fnas_pkg::next_column(pos.col_next, eff_w);
      pos.fill_col  = col_ff;
      pos.fill_next = fnas_pkg::next_column(col_ff, eff_w);
      pos.interior  = (r >= fnas_pkg::ROW_W'(2)) && (r < eff_h) && (c != '0)
                      && ((c_ext + fnas_pkg::LEN_W'(2)) <= eff_w);
      pos.last      = (r == (eff_h - fnas_pkg::ROW_W'(1)))
                      && (c_ext == (eff_w - fnas_pkg::LEN_W'(2)));
   end

   // Wrap the column at the row end and the row at the frame end.
   always_comb begin
      if ((c_ext + fnas_pkg::LEN_W'(1)) >= eff_w) begin
         col_in = '0;
         row_in = (r_inc >= {1'b0, eff_h}) ? '0 : r_inc[fnas_pkg::ROW_W-1:0];
      end else begin
         col_in = pos.col_next;
         row_in = r;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_length_ff <= fnas_pkg::ROW_LENGTH_RESET;
         row_count_ff  <= fnas_pkg::ROW_COUNT_RESET;
         row_ff        <= '0;
         col_ff        <= '0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               fnas_pkg::REG_ROW_LENGTH: row_length_ff <= csr_data[fnas_pkg::LEN_W-1:0];
               fnas_pkg::REG_ROW_COUNT:  row_count_ff  <= csr_data[fnas_pkg::ROW_W-1:0];
               default: ;
            endcase
         end
         if (rewind) begin
            row_ff <= '0;
            col_ff <= '0;
         end else if (advance) begin
            row_ff <= row_in;
            col_ff <= col_in;
         end
      end
   end

endmodule

// ===== rtl/core/fnas_out_buffer.sv =====
`timescale 1ns / 1ps
// Output register with a skid entry between the stencil datapath and the result channel.
module fnas_out_buffer (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  fnas_pkg::result_type push_data,
   input  logic                 rsp_stall,
   output logic                 full,
   output logic                 rsp_valid,
   output fnas_pkg::result_type rsp_data
);

   logic                 out_vld_ff, out_vld_in;
   logic                 skid_vld_ff, skid_vld_in;
   fnas_pkg::result_type out_ff, out_in;
   fnas_pkg::result_type skid_ff, skid_in;
   logic                 pop;

   assign pop = out_vld_ff && !rsp_stall;

   always_comb begin
      out_vld_in  = out_vld_ff;
      skid_vld_in = skid_vld_ff;
      out_in      = out_ff;
      skid_in     = skid_ff;
      if (pop || !out_vld_ff) begin
         // Output slot frees up: drain the skid entry first, else take the new transfer.
         if (skid_vld_ff) begin
            out_in      = skid_ff;
            out_vld_in  = 1'b1;
            skid_vld_in = 1'b0;
         end else begin
            out_in     = push_data;
            out_vld_in = push;
         end
      end else if (push) begin
         skid_in     = push_data;
         skid_vld_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else begin
         out_vld_ff  <= out_vld_in;
         skid_vld_ff <= skid_vld_in;
      end
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign full      = skid_vld_ff;
   assign rsp_valid = out_vld_ff;
   assign rsp_data  = out_ff;

endmodule

// ===== rtl/core/fnas_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for the stencil core, bound to the top level.
module fnas_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  req_valid,
   input logic                                  req_stall,
   input logic [fnas_pkg::PIXEL_W-1:0]          req_pixel,
   input logic                                  req_frame_start,
   input logic                                  rsp_valid,
   input logic                                  rsp_stall,
   input logic [fnas_pkg::PIXEL_W-1:0]          rsp_average,
   input logic [fnas_pkg::ROW_W-1:0]            rsp_row_index,
   input logic [fnas_pkg::COL_W-1:0]            rsp_column_index,
   input logic                                  rsp_frame_last,
   input logic                                  csr_write,
   input logic [fnas_pkg::CSR_INDEX_W-1:0]      csr_index,
   input logic [fnas_pkg::CSR_DATA_W-1:0]       csr_data
);

   // Reset empties the result buffer.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid high right after reset");

   // A stalled result holds until its transfer.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_average)
         && $stable(rsp_row_index) && $stable(rsp_column_index) && $stable(rsp_frame_last))
      else $error("stalled result changed");

   // Border pixels in row zero or column zero never produce a result.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_row_index != '0 && rsp_column_index != '0)
      else $error("result centred on a border pixel");

   // The column window reloads after reset and after a register write.
   assert property (@(posedge clock) reset || csr_write |=> req_stall)
      else $error("input not held off during window reload");

endmodule

bind four_neighbour_average_stencil_core fnas_checker u_fnas_checker (.*);
